FILE: hdl/abs_pkg.sv
// abs_pkg: shared types, constants and codes of the alternating bit sender
// no dependencies; used by the channel interfaces and the top level
package abs_pkg;

	localparam int unsigned PAYLOAD_WORDS = 5;
	localparam int unsigned WORD_W        = 32;
	localparam int unsigned TIMER_W       = 16;
	localparam int unsigned OP_W          = 2;
	localparam int unsigned STATUS_W      = 3;

	localparam logic [WORD_W-1:0]  CHECK_SEED    = 32'h5969_6E67;
	localparam logic [TIMER_W-1:0] TIMEOUT_RESET = 16'd16;

	typedef logic [WORD_W-1:0]  word_t;
	typedef logic [TIMER_W-1:0] tick_t;
	typedef word_t payload_t [PAYLOAD_WORDS];

	typedef enum logic [OP_W-1:0] {
		OP_MESSAGE = 2'd0,
		OP_PACKET  = 2'd1,
		OP_TICK    = 2'd2,
		OP_UNUSED  = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_SENT_NEW      = 3'd0,
		ST_DROPPED_BUSY  = 3'd1,
		ST_RESENT_CORRUPT = 3'd2,
		ST_RESENT_BIT    = 3'd3,
		ST_ACKED         = 3'd4,
		ST_IGNORED_IDLE  = 3'd5,
		ST_TIMEOUT_RESEND = 3'd6,
		ST_TICK_ONLY     = 3'd7
	} status_t;

endpackage

FILE: hdl/abs_ifs.sv
// abs_ifs: valid/ready channel interfaces of the alternating bit sender
// depends on abs_pkg
interface abs_req_if;
	import abs_pkg::*;
	logic  valid;
	logic  ready;
	logic [OP_W-1:0] op;
	word_t word0;
	word_t word1;
	word_t word2;
	word_t word3;
	word_t word4;
	word_t in_seq;
	word_t in_bit;
	word_t in_check;
	modport source (output valid, op, word0, word1, word2, word3, word4, in_seq, in_bit,
		in_check, input ready);
	modport sink (input valid, op, word0, word1, word2, word3, word4, in_seq, in_bit,
		in_check, output ready);
endinterface

interface abs_rsp_if;
	import abs_pkg::*;
	logic  valid;
	logic  ready;
	logic [STATUS_W-1:0] status;
	logic  transmit;
	word_t out_seq;
	logic  out_bit;
	word_t out_check;
	word_t out_word0;
	word_t out_word1;
	word_t out_word2;
	word_t out_word3;
	word_t out_word4;
	modport source (output valid, status, transmit, out_seq, out_bit, out_check, out_word0,
		out_word1, out_word2, out_word3, out_word4, input ready);
	modport sink (input valid, status, transmit, out_seq, out_bit, out_check, out_word0,
		out_word1, out_word2, out_word3, out_word4, output ready);
endinterface

interface abs_cfg_if;
	import abs_pkg::*;
	logic  valid;
	logic  ready;
	tick_t data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

FILE: hdl/alternating_bit_sender.sv
// alternating_bit_sender: stop-and-wait sender with one alternating bit
// depends on abs_pkg and the channel interfaces in abs_ifs
//
// Every accepted event (message, network packet or timer tick) gives exactly one
// result transaction. An event is captured in an input register, processed against
// the sender state in one pass of logic and lands in the result register, so one
// event is taken in every cycle as long as results are taken; a result that is not
// taken holds the result register, and one more event may wait in the input
// register before req.ready drops. The timeout register is written through cfg at
// any cycle and is read when a new packet is sent and when a timer resend goes out.
module alternating_bit_sender (
	input  logic              clk,
	input  logic              arst_n,
	abs_req_if.sink           req,
	abs_rsp_if.source         rsp,
	abs_cfg_if.sink           cfg
);
	import abs_pkg::*;

	// input stage
	logic                valid_s1;
	logic [OP_W-1:0]     op_s1;
	payload_t            words_s1;
	word_t               seq_s1;
	word_t               bit_s1;
	word_t               check_s1;

	// result stage
	logic                valid_s2;
	logic [STATUS_W-1:0] status_s2;
	logic                transmit_s2;
	word_t               seq_s2;
	logic                bit_s2;
	word_t               check_s2;
	payload_t            words_s2;

	// sender state
	tick_t               timeout_q;
	logic                busy_q;
	logic                cur_bit_q;
	word_t               next_seq_q;
	word_t               held_seq_q;
	payload_t            held_payload_q;
	word_t               held_check_q;
	tick_t               timer_left_q;
	logic                timer_on_q;

	logic                advance;
	logic                take_s1;

	// next-state and result logic
	logic                busy_d;
	logic                cur_bit_d;
	word_t               next_seq_d;
	logic                load_held;
	word_t               new_check;
	word_t               rx_sum;
	tick_t               timer_left_d;
	logic                timer_on_d;
	logic [STATUS_W-1:0] status_d;
	logic                transmit_d;

	assign advance   = !valid_s2 || rsp.ready;
	assign take_s1   = valid_s1 && advance;
	assign req.ready = !valid_s1 || advance;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			op_s1       <= req.op;
			words_s1[0] <= req.word0;
			words_s1[1] <= req.word1;
			words_s1[2] <= req.word2;
			words_s1[3] <= req.word3;
			words_s1[4] <= req.word4;
			seq_s1      <= req.in_seq;
			bit_s1      <= req.in_bit;
			check_s1    <= req.in_check;
		end
	end

	always_comb begin
		new_check = CHECK_SEED ^ next_seq_q ^ {{(WORD_W-1){1'b0}}, !cur_bit_q};
		rx_sum    = CHECK_SEED ^ seq_s1 ^ bit_s1;
		for (int i = 0; i < PAYLOAD_WORDS; i++) begin
			new_check = new_check ^ words_s1[i];
			rx_sum    = rx_sum ^ words_s1[i];
		end
	end

	always_comb begin
		busy_d       = busy_q;
		cur_bit_d    = cur_bit_q;
		next_seq_d   = next_seq_q;
		load_held    = 1'b0;
		timer_left_d = timer_left_q;
		timer_on_d   = timer_on_q;
		status_d     = ST_TICK_ONLY;
		transmit_d   = 1'b0;
		case (op_t'(op_s1))
			OP_MESSAGE: begin
				if (busy_q) begin
					status_d = ST_DROPPED_BUSY;
				end else begin
					load_held    = 1'b1;
					next_seq_d   = next_seq_q + 1'b1;
					cur_bit_d    = !cur_bit_q;
					busy_d       = 1'b1;
					timer_left_d = timeout_q;
					timer_on_d   = 1'b1;
					status_d     = ST_SENT_NEW;
					transmit_d   = 1'b1;
				end
			end
			OP_PACKET: begin
				if (!busy_q) begin
					status_d = ST_IGNORED_IDLE;
				end else if (rx_sum != check_s1) begin
					status_d   = ST_RESENT_CORRUPT;
					transmit_d = 1'b1;
				end else if (bit_s1 != {{(WORD_W-1){1'b0}}, cur_bit_q}) begin
					status_d   = ST_RESENT_BIT;
					transmit_d = 1'b1;
				end else begin
					timer_on_d   = 1'b0;
					timer_left_d = '0;
					busy_d       = 1'b0;
					status_d     = ST_ACKED;
				end
			end
			OP_TICK: begin
				if (timer_on_q) begin
					if (timer_left_q <= tick_t'(1)) begin
						timer_on_d   = 1'b0;
						timer_left_d = '0;
						if (busy_q) begin
							timer_on_d   = 1'b1;
							timer_left_d = timeout_q;
							status_d     = ST_TIMEOUT_RESEND;
							transmit_d   = 1'b1;
						end
					end else begin
						timer_left_d = timer_left_q - 1'b1;
					end
				end
			end
			default: begin
				status_d = ST_TICK_ONLY;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q    <= TIMEOUT_RESET;
			busy_q       <= 1'b0;
			cur_bit_q    <= 1'b1;
			next_seq_q   <= '0;
			timer_left_q <= '0;
			timer_on_q   <= 1'b0;
			valid_s2     <= 1'b0;
			status_s2    <= ST_TICK_ONLY;
			transmit_s2  <= 1'b0;
		end else begin
			if (cfg.valid) begin
				timeout_q <= cfg.data;
			end
			if (take_s1) begin
				busy_q       <= busy_d;
				cur_bit_q    <= cur_bit_d;
				next_seq_q   <= next_seq_d;
				timer_left_q <= timer_left_d;
				timer_on_q   <= timer_on_d;
				status_s2    <= status_d;
				transmit_s2  <= transmit_d;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// held packet and transmitted fields, zero when nothing goes out
	always_ff @(posedge clk) begin
		if (take_s1 && load_held) begin
			held_seq_q     <= next_seq_q;
			held_payload_q <= words_s1;
			held_check_q   <= new_check;
		end
		if (take_s1) begin
			if (!transmit_d) begin
				seq_s2   <= '0;
				bit_s2   <= 1'b0;
				check_s2 <= '0;
				for (int i = 0; i < PAYLOAD_WORDS; i++) begin
					words_s2[i] <= '0;
				end
			end else if (load_held) begin
				seq_s2   <= next_seq_q;
				bit_s2   <= cur_bit_d;
				check_s2 <= new_check;
				words_s2 <= words_s1;
			end else begin
				seq_s2   <= held_seq_q;
				bit_s2   <= cur_bit_q;
				check_s2 <= held_check_q;
				words_s2 <= held_payload_q;
			end
		end
	end

	assign rsp.valid     = valid_s2;
	assign rsp.status    = status_s2;
	assign rsp.transmit  = transmit_s2;
	assign rsp.out_seq   = seq_s2;
	assign rsp.out_bit   = bit_s2;
	assign rsp.out_check = check_s2;
	assign rsp.out_word0 = words_s2[0];
	assign rsp.out_word1 = words_s2[1];
	assign rsp.out_word2 = words_s2[2];
	assign rsp.out_word3 = words_s2[3];
	assign rsp.out_word4 = words_s2[4];

endmodule

FILE: verif/sender_checker.sv
// sender_checker: watches the event, result and timeout channels of the alternating bit
// sender, predicts every result from its own copy of the sender state and compares
// depends on abs_pkg and the channel interfaces in abs_ifs
`timescale 1ns / 100ps

module sender_checker (
	input  logic clk,
	input  logic arst_n,
	abs_req_if   req,
	abs_rsp_if   rsp,
	abs_cfg_if   cfg,
	output int   errors,
	output int   pending,
	output int   n_results,
	output int   n_acked,
	output int   n_timeouts
);
	import abs_pkg::*;

	typedef struct packed {
		status_t                  status;
		logic                     tx;
		word_t                    seq;
		logic                     ab;
		word_t                    sum;
		word_t [PAYLOAD_WORDS-1:0] words;
	} reply_t;

	reply_t   replies [$];

	tick_t    timeout;
	logic     busy;
	logic     cur_bit;
	word_t    next_seq;
	word_t    held_seq;
	payload_t held_words;
	word_t    held_sum;
	tick_t    timer_left;
	logic     timer_on;

	function automatic word_t packet_sum(input payload_t w, input word_t s, input word_t a);
		word_t c;
		c = CHECK_SEED;
		for (int i = 0; i < PAYLOAD_WORDS; i++) c ^= w[i];
		return c ^ s ^ a;
	endfunction

	function automatic reply_t held_packet(input status_t st);
		reply_t r;
		r = '0;
		r.status = st;
		r.tx = 1'b1;
		r.seq = held_seq;
		r.ab = cur_bit;
		r.sum = held_sum;
		for (int i = 0; i < PAYLOAD_WORDS; i++) r.words[i] = held_words[i];
		return r;
	endfunction

	function automatic reply_t advance_sender(input op_t op, input payload_t w, input word_t s,
		input word_t a, input word_t c);
		reply_t r;
		r = '0;
		r.status = ST_TICK_ONLY;
		case (op)
			OP_MESSAGE: begin
				if (busy) begin
					r.status = ST_DROPPED_BUSY;
				end else begin
					held_seq = next_seq;
					next_seq = next_seq + 1;
					cur_bit = ~cur_bit;
					held_words = w;
					held_sum = packet_sum(w, held_seq, {31'b0, cur_bit});
					busy = 1'b1;
					timer_left = timeout;
					timer_on = 1'b1;
					r = held_packet(ST_SENT_NEW);
				end
			end
			OP_PACKET: begin
				if (!busy) begin
					r.status = ST_IGNORED_IDLE;
				end else if (packet_sum(w, s, a) != c) begin
					r = held_packet(ST_RESENT_CORRUPT);
				end else if (a != {31'b0, cur_bit}) begin
					r = held_packet(ST_RESENT_BIT);
				end else begin
					timer_on = 1'b0;
					timer_left = '0;
					busy = 1'b0;
					r.status = ST_ACKED;
				end
			end
			OP_TICK: begin
				if (timer_on && timer_left <= 1) begin
					timer_on = 1'b0;
					timer_left = '0;
					if (busy) begin
						r = held_packet(ST_TIMEOUT_RESEND);
						timer_left = timeout;
						timer_on = 1'b1;
					end
				end else if (timer_on) begin
					timer_left = timer_left - 1;
				end
			end
			default: r.status = ST_TICK_ONLY;
		endcase
		return r;
	endfunction

	task automatic match_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			errors++;
			$error("%s: expected %h, got %h", name, want, got);
		end
	endtask

	task automatic check_reply();
		reply_t r;
		if (replies.size() == 0) begin
			errors++;
			$error("status: expected no transaction, got %0d", rsp.status);
		end else begin
			r = replies.pop_front();
			n_results++;
			if (r.status == ST_ACKED) n_acked++;
			if (r.status == ST_TIMEOUT_RESEND) n_timeouts++;
			match_field("status", r.status, rsp.status);
			match_field("transmit", r.tx, rsp.transmit);
			match_field("out_seq", r.seq, rsp.out_seq);
			match_field("out_bit", r.ab, rsp.out_bit);
			match_field("out_check", r.sum, rsp.out_check);
			match_field("out_word0", r.words[0], rsp.out_word0);
			match_field("out_word1", r.words[1], rsp.out_word1);
			match_field("out_word2", r.words[2], rsp.out_word2);
			match_field("out_word3", r.words[3], rsp.out_word3);
			match_field("out_word4", r.words[4], rsp.out_word4);
		end
	endtask

	task automatic take_event();
		payload_t w;
		w[0] = req.word0;
		w[1] = req.word1;
		w[2] = req.word2;
		w[3] = req.word3;
		w[4] = req.word4;
		replies.push_back(advance_sender(op_t'(req.op), w, req.in_seq, req.in_bit,
			req.in_check));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout = TIMEOUT_RESET;
			busy = 1'b0;
			cur_bit = 1'b1;
			next_seq = '0;
			held_seq = '0;
			held_words = '{default: '0};
			held_sum = '0;
			timer_left = '0;
			timer_on = 1'b0;
			replies.delete();
			errors = 0;
			n_results = 0;
			n_acked = 0;
			n_timeouts = 0;
		end else begin
			if (rsp.valid === 1'b1 && rsp.ready === 1'b1) check_reply();
			if (cfg.valid === 1'b1 && cfg.ready === 1'b1) timeout = cfg.data;
			if (req.valid === 1'b1 && req.ready === 1'b1) take_event();
		end
		pending = replies.size();
	end

endmodule

FILE: verif/tb.sv
// tb: drives messages, network packets and timer ticks into the alternating bit sender
// under several timeout settings with random sender gaps and receiver stalls
// depends on abs_pkg, abs_ifs, alternating_bit_sender and sender_checker
`timescale 1ns / 100ps

module tb;
	import abs_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int          PHASE_ITEMS = 165;
	localparam int          HOLD_CYCLES = 120;

	logic clk = 1'b0;
	logic arst_n;

	abs_req_if req ();
	abs_rsp_if rsp ();
	abs_cfg_if cfg ();

	int errors, pending, n_results, n_acked, n_timeouts;

	int unsigned cycles = 0;
	int unsigned rx_cycle = 0;
	int          hold_cnt = 0;
	logic        hold_go;
	logic        quiet;
	int          burst_left;
	int unsigned sent;
	int          tick_span;

	always #2 clk = ~clk;

	alternating_bit_sender i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	sender_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.rsp        (rsp),
		.cfg        (cfg),
		.errors     (errors),
		.pending    (pending),
		.n_results  (n_results),
		.n_acked    (n_acked),
		.n_timeouts (n_timeouts)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// receiver: one long hold-off on request, otherwise a rotating stall pattern
	always @(posedge clk) begin
		rx_cycle <= rx_cycle + 1;
		if (hold_go && hold_cnt < HOLD_CYCLES) begin
			hold_cnt <= hold_cnt + 1;
			rsp.ready <= 1'b0;
		end else begin
			case ((rx_cycle / 300) % 4)
				0: rsp.ready <= 1'b1;
				1: rsp.ready <= ($urandom_range(0, 9) >= 3);
				2: rsp.ready <= ((rx_cycle % 5) < 3);
				default: rsp.ready <= ($urandom_range(0, 9) >= 7);
			endcase
		end
	end

	function automatic word_t seal(input payload_t w, input word_t s, input word_t a);
		word_t c;
		c = CHECK_SEED ^ s ^ a;
		for (int i = 0; i < PAYLOAD_WORDS; i++) c ^= w[i];
		return c;
	endfunction

	function automatic payload_t rand_words();
		payload_t w;
		for (int i = 0; i < PAYLOAD_WORDS; i++) w[i] = $urandom;
		return w;
	endfunction

	task automatic offer(input op_t op, input payload_t w, input word_t s, input word_t a,
		input word_t c);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = quiet ? 0 : $urandom_range(0, 10);
			if (gap != 0) begin
				req.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req.op <= op;
		req.word0 <= w[0];
		req.word1 <= w[1];
		req.word2 <= w[2];
		req.word3 <= w[3];
		req.word4 <= w[4];
		req.in_seq <= s;
		req.in_bit <= a;
		req.in_check <= c;
		req.valid <= 1'b1;
		do @(posedge clk); while (req.ready !== 1'b1);
		sent++;
	endtask

	task automatic message(input payload_t w);
		offer(OP_MESSAGE, w, $urandom, $urandom, $urandom);
	endtask

	task automatic tick();
		offer(OP_TICK, rand_words(), $urandom, $urandom, $urandom);
	endtask

	task automatic good_packet(input word_t a);
		payload_t w;
		word_t    s;
		w = rand_words();
		s = $urandom;
		offer(OP_PACKET, w, s, a, seal(w, s, a));
	endtask

	task automatic bad_packet();
		payload_t w;
		word_t    s;
		word_t    a;
		w = rand_words();
		s = $urandom;
		a = $urandom_range(0, 1);
		offer(OP_PACKET, w, s, a, seal(w, s, a) ^ ($urandom | 32'h1));
	endtask

	task automatic noise();
		payload_t w;
		word_t    s;
		word_t    a;
		w = rand_words();
		s = $urandom;
		a = $urandom_range(0, 1) ? word_t'($urandom_range(0, 1)) : word_t'($urandom);
		offer(op_t'($urandom_range(0, 3)), w, s, a,
			$urandom_range(0, 1) ? seal(w, s, a) : word_t'($urandom));
	endtask

	// one message followed by disturbances and a closing acknowledgement on both bits
	task automatic exchange();
		int k;
		message(rand_words());
		k = $urandom_range(0, 4);
		repeat (k) begin
			case ($urandom_range(0, 5))
				0: repeat ($urandom_range(1, tick_span)) tick();
				1: bad_packet();
				2: good_packet($urandom);
				3: message(rand_words());
				4: offer(OP_UNUSED, rand_words(), $urandom, $urandom, $urandom);
				default: tick();
			endcase
		end
		if ($urandom_range(0, 1)) begin
			good_packet(0);
			good_packet(1);
		end else begin
			good_packet(1);
			good_packet(0);
		end
	endtask

	task automatic settle();
		req.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_timeout(input tick_t v);
		settle();
		cfg.data <= v;
		cfg.valid <= 1'b1;
		do @(posedge clk); while (cfg.ready !== 1'b1);
		cfg.valid <= 1'b0;
		tick_span = (v == 0) ? 2 : (v > 18) ? 20 : v + 2;
	endtask

	initial begin
		payload_t    zeros;
		payload_t    ones;
		tick_t       phase_timeout [7];
		int unsigned phase_end;
		zeros = '{default: '0};
		ones = '{default: '1};
		phase_timeout = '{16'd3, 16'd1, 16'd0, 16'd65535, 16'd2, 16'd5, 16'd16};
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.op = OP_MESSAGE;
		req.word0 = '0;
		req.word1 = '0;
		req.word2 = '0;
		req.word3 = '0;
		req.word4 = '0;
		req.in_seq = '0;
		req.in_bit = '0;
		req.in_check = '0;
		cfg.valid = 1'b0;
		cfg.data = '0;
		rsp.ready = 1'b0;
		hold_go = 1'b0;
		quiet = 1'b0;
		burst_left = 0;
		sent = 0;
		tick_span = 18;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// idle sender: tick, stray packet, unused op
		offer(OP_TICK, zeros, '0, '0, '0);
		offer(OP_PACKET, ones, '1, '1, '1);
		offer(OP_UNUSED, ones, '1, '1, '1);
		// send, drop while busy, bad packets, then acknowledge
		message(zeros);
		message(ones);
		offer(OP_PACKET, ones, '1, 0, seal(ones, '1, 0) ^ 32'h1);
		offer(OP_PACKET, zeros, '1, 1, seal(zeros, '1, 1));
		offer(OP_PACKET, ones, 0, 32'hFFFF_FFFE, seal(ones, 0, 32'hFFFF_FFFE));
		offer(OP_PACKET, zeros, 0, 0, seal(zeros, 0, 0));
		message(ones);
		good_packet(1);
		// timeout of one: every tick expires
		write_timeout(16'd1);
		message(rand_words());
		tick();
		tick();
		good_packet(0);
		// zero timeout
		write_timeout(16'd0);
		message(rand_words());
		tick();
		good_packet(1);
		tick();
		// corrupt packet does not re-arm the timer
		write_timeout(16'd2);
		message(rand_words());
		tick();
		tick();
		bad_packet();
		tick();
		tick();
		good_packet(0);

		for (int p = 0; p < 7; p++) begin
			write_timeout(phase_timeout[p]);
			quiet = (p == 5) || ($urandom_range(0, 3) == 0);
			if (p == 1) hold_go <= 1'b1;
			phase_end = sent + PHASE_ITEMS;
			while (sent < phase_end) begin
				if (p == 4 && sent + PHASE_ITEMS / 2 == phase_end) settle();
				if ($urandom_range(0, 99) < 85) exchange();
				else noise();
			end
		end

		settle();
		repeat (8) @(posedge clk);
		$display("covered %0d events under timeouts 16, 1, 0, 2, 3, 65535 and 5", sent);
		$display("%0d results checked: %0d acknowledged, %0d timer resends",
			n_results, n_acked, n_timeouts);
		if (errors == 0 && pending == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
